// ===== src/mcstg_pkg.sv =====
package mcstg_pkg;

	// Fixed field widths of the ports
	localparam int TIME_W = 32;
	localparam int MASK_W = 4;
	localparam int CNT_W  = 3;
	localparam int IDX_W  = 3;

	// Defaults for the top-level parameters
	localparam int NUM_CH_DEF    = 4;
	localparam int TIME_BITS_DEF = 32;

	// Number of channels that own a duration register
	localparam int DUR_CFG = 4;

	// Register reset values
	localparam logic [TIME_W-1:0] DUR_RESET    = 32'd1000;
	localparam logic [MASK_W-1:0] REPEAT_RESET = 4'hF;
	localparam logic [MASK_W-1:0] TASKS_RESET  = 4'hF;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_COUNT  = 3'd0,
		REG_DUR0   = 3'd1,
		REG_DUR1   = 3'd2,
		REG_DUR2   = 3'd3,
		REG_DUR3   = 3'd4,
		REG_REPEAT = 3'd5,
		REG_TASKS  = 3'd6
	} reg_idx_t;

	// Channel phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_RUNNING = 3'b010,
		PH_EXPIRED = 3'b100
	} phase_t;

	// Mode and count registers seen by the channels
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [MASK_W-1:0] repeating;
		logic [MASK_W-1:0] tasks;
	} cfg_flags_t;

	// Per-channel outcome of one tick
	typedef struct packed {
		logic fired;
		logic late;
		logic missing;
		logic slow;
	} chan_res_t;

endpackage

// ===== src/mcstg_cfg.sv =====
module mcstg_cfg #(
	parameter int NUM_CHANNELS = mcstg_pkg::NUM_CH_DEF,
	parameter int TIME_BITS    = mcstg_pkg::TIME_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_we,
	input  logic [mcstg_pkg::IDX_W-1:0]                  cfg_index,
	input  logic [mcstg_pkg::TIME_W-1:0]                 cfg_data,
	output mcstg_pkg::cfg_flags_t                        flags,
	output logic [NUM_CHANNELS-1:0][TIME_BITS-1:0]       dur
);
	import mcstg_pkg::*;

	localparam logic [TIME_BITS-1:0] DUR_RST_T = TIME_BITS'(DUR_RESET);

	logic [TIME_BITS-1:0] wval;
	logic [CNT_W-1:0]     count_q;
	logic [MASK_W-1:0]    repeat_q;
	logic [MASK_W-1:0]    tasks_q;

	// Fit write data to the time width
	if (TIME_BITS <= TIME_W) begin : g_trunc
		assign wval = cfg_data[TIME_BITS-1:0];
	end else begin : g_ext
		assign wval = {{(TIME_BITS-TIME_W){1'b0}}, cfg_data};
	end

	// Count and mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			repeat_q <= REPEAT_RESET;
			tasks_q  <= TASKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUNT:  count_q  <= cfg_data[CNT_W-1:0];
				REG_REPEAT: repeat_q <= cfg_data[MASK_W-1:0];
				REG_TASKS:  tasks_q  <= cfg_data[MASK_W-1:0];
				default:    ;
			endcase
		end
	end

	// Duration registers; channels past the register list keep the reset period
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_dur
		if (i < DUR_CFG) begin : g_reg
			logic [TIME_BITS-1:0] dur_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dur_q <= DUR_RST_T;
				end else if (cfg_we && cfg_index == IDX_W'(int'(REG_DUR0) + i)) begin
					dur_q <= wval;
				end
			end
			assign dur[i] = dur_q;
		end else begin : g_fix
			assign dur[i] = DUR_RST_T;
		end
	end

	assign flags.count     = count_q;
	assign flags.repeating = repeat_q;
	assign flags.tasks     = tasks_q;

endmodule

// ===== src/mcstg_chan.sv =====
module mcstg_chan #(
	parameter int TIME_BITS = mcstg_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  logic                  en,
	input  logic                  repeating,
	input  logic                  task_ok,
	input  logic [TIME_BITS-1:0]  t,
	input  logic [TIME_BITS-1:0]  delta,
	input  logic [TIME_BITS-1:0]  dur,
	output mcstg_pkg::chan_res_t  res
);
	import mcstg_pkg::*;

	logic [TIME_BITS-1:0] start_q;
	phase_t               phase_q;

	logic [TIME_BITS-1:0] start_eff;
	logic [TIME_BITS-1:0] due;
	logic [TIME_BITS-1:0] limit;
	logic                 fire;
	logic [TIME_BITS-1:0] start_nx;
	phase_t               phase_nx;

	// A channel that is not running starts at this tick
	assign start_eff = (phase_q == PH_RUNNING) ? start_q : t;
	assign due       = start_eff + dur;
	assign limit     = start_eff + {dur[TIME_BITS-2:0], 1'b0};
	assign fire      = en && (t >= due);

	assign res.fired   = fire;
	assign res.late    = fire && repeating && (t > limit);
	assign res.missing = fire && !task_ok;
	assign res.slow    = en && (delta > dur);

	// Restart a repeating channel, expire a one-shot one
	always_comb begin
		start_nx = start_eff;
		phase_nx = PH_RUNNING;
		if (fire) begin
			if (repeating) begin
				start_nx = t;
			end else begin
				phase_nx = PH_EXPIRED;
			end
		end
	end

	// Hold state for channels not in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			phase_q <= PH_IDLE;
		end else if (upd && en) begin
			start_q <= start_nx;
			phase_q <= phase_nx;
		end
	end

endmodule

// ===== src/multi_channel_soft_timer_group.sv =====
// Group of periodic timer channels driven by millisecond ticks. Each accepted
// beat carries the current time; every channel in use compares it against its
// start plus duration in parallel, and one result beat (fired, late, overrun,
// all_ok) comes out per tick. Each tick is registered at the input, evaluated by
// the per-channel adders and comparators, and lands in the output register,
// where its result is offered; a new tick can be taken every cycle while the
// output is not stalled. Channel state is updated as a tick moves into the
// output register, so the next tick sees it. The output register and input
// register together let a tick be taken while a result waits.
module multi_channel_soft_timer_group #(
	parameter int NUM_CHANNELS = mcstg_pkg::NUM_CH_DEF,
	parameter int TIME_BITS    = mcstg_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcstg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [mcstg_pkg::TIME_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mcstg_pkg::TIME_W-1:0]  tick_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mcstg_pkg::MASK_W-1:0]  fired_mask,
	output logic [mcstg_pkg::MASK_W-1:0]  late_mask,
	output logic                          overrun,
	output logic                          all_ok
);
	import mcstg_pkg::*;

	cfg_flags_t                            flags;
	logic [NUM_CHANNELS-1:0][TIME_BITS-1:0] dur;

	logic [TIME_BITS-1:0] t_in;
	logic                 valid_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [TIME_BITS-1:0] prev_q;
	logic [TIME_BITS-1:0] delta;
	logic                 adv;
	logic                 go;

	logic [NUM_CHANNELS+MASK_W-1:0] rep_ext;
	logic [NUM_CHANNELS+MASK_W-1:0] tasks_ext;
	chan_res_t [NUM_CHANNELS-1:0]   res;
	logic [NUM_CHANNELS-1:0]        fired;
	logic [NUM_CHANNELS-1:0]        late;
	logic [NUM_CHANNELS-1:0]        missing;
	logic [NUM_CHANNELS-1:0]        slow;
	logic [NUM_CHANNELS+MASK_W-1:0] fired_ext;
	logic [NUM_CHANNELS+MASK_W-1:0] late_ext;
	logic                           ovr;

	logic                 valid_s2;
	logic [MASK_W-1:0]    fired_s2;
	logic [MASK_W-1:0]    late_s2;
	logic                 ovr_s2;
	logic                 ok_s2;

	mcstg_cfg #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TIME_BITS    (TIME_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.flags     (flags),
		.dur       (dur)
	);

	// Fit the incoming time to the time width
	if (TIME_BITS <= TIME_W) begin : g_trunc
		assign t_in = tick_ms[TIME_BITS-1:0];
	end else begin : g_ext
		assign t_in = {{(TIME_BITS-TIME_W){1'b0}}, tick_ms};
	end

	// Handshake: input stage advances when the output register frees up
	assign adv      = !valid_s2 || !out_stall;
	assign go       = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			time_s1 <= t_in;
		end
	end

	// Previous tick time, updated on every evaluated tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (go) begin
			prev_q <= time_s1;
		end
	end

	assign delta     = time_s1 - prev_q;
	assign rep_ext   = {{NUM_CHANNELS{1'b0}}, flags.repeating};
	assign tasks_ext = {{NUM_CHANNELS{1'b0}}, flags.tasks};

	// One cell per channel
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
		logic en;
		assign en = (32'(flags.count) > i);

		mcstg_chan #(
			.TIME_BITS (TIME_BITS)
		) u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.upd       (go),
			.en        (en),
			.repeating (rep_ext[i]),
			.task_ok   (tasks_ext[i]),
			.t         (time_s1),
			.delta     (delta),
			.dur       (dur[i]),
			.res       (res[i])
		);

		assign fired[i]   = res[i].fired;
		assign late[i]    = res[i].late;
		assign missing[i] = res[i].missing;
		assign slow[i]    = res[i].slow;
	end

	// Overrun: the gap exceeds the smallest duration iff it exceeds any one of them
	assign ovr       = |slow;
	assign fired_ext = {{MASK_W{1'b0}}, fired};
	assign late_ext  = {{MASK_W{1'b0}}, late};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			fired_s2 <= fired_ext[MASK_W-1:0];
			late_s2  <= late_ext[MASK_W-1:0];
			ovr_s2   <= ovr;
			ok_s2    <= !ovr && !(|late) && !(|missing);
		end
	end

	assign out_valid  = valid_s2;
	assign fired_mask = fired_s2;
	assign late_mask  = late_s2;
	assign overrun    = ovr_s2;
	assign all_ok     = ok_s2;

`ifndef ASSERT_OFF
	a_late_fired: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((late_s2 & ~fired_s2) == '0))
		else $error("late channel that did not fire");

	a_ovr_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ovr_s2) |-> !ok_s2)
		else $error("all_ok set together with overrun");

	a_prev_follow: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (prev_q == $past(time_s1)))
		else $error("previous tick time not updated");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall))
		else $error("input stalled while output register free");
`endif

endmodule

// ===== sim/tick_check_pkg.sv =====
`timescale 1ns / 100ps

package tick_check_pkg;
	import mcstg_pkg::*;

	// One expected result beat
	typedef struct packed {
		logic [MASK_W-1:0] fired;
		logic [MASK_W-1:0] late;
		logic              overrun;
		logic              all_ok;
	} tick_outcome_t;

	// Tracks channel state and configuration, predicts each tick, checks result beats
	class timer_scoreboard;
		logic [CNT_W-1:0]  chan_count;
		logic [TIME_W-1:0] duration [DUR_CFG];
		logic [MASK_W-1:0] repeating;
		logic [MASK_W-1:0] tasks;
		logic [TIME_W-1:0] start_time [NUM_CH_DEF];
		phase_t            chan_phase [NUM_CH_DEF];
		logic [TIME_W-1:0] last_tick;
		tick_outcome_t     outcomes_due [$];
		int                errors;

		function new();
			chan_count = '0;
			repeating = REPEAT_RESET;
			tasks = TASKS_RESET;
			last_tick = '0;
			errors = 0;
			for (int i = 0; i < DUR_CFG; i++) duration[i] = DUR_RESET;
			for (int i = 0; i < NUM_CH_DEF; i++) begin
				start_time[i] = '0;
				chan_phase[i] = PH_IDLE;
			end
		endfunction

		// Mirror a register write; unknown indexes are dropped
		function void write_reg(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] data);
			case (idx)
				REG_COUNT:  chan_count = data[CNT_W-1:0];
				REG_DUR0:   duration[0] = data;
				REG_DUR1:   duration[1] = data;
				REG_DUR2:   duration[2] = data;
				REG_DUR3:   duration[3] = data;
				REG_REPEAT: repeating = data[MASK_W-1:0];
				REG_TASKS:  tasks = data[MASK_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the channels by one accepted tick and queue its outcome
		function void note_tick(logic [TIME_W-1:0] t);
			tick_outcome_t     o;
			int                n;
			logic [TIME_W-1:0] min_dur;
			logic [TIME_W-1:0] since_last;
			logic [TIME_W-1:0] due;
			logic [TIME_W-1:0] late_at;
			logic              missing;
			o = '0;
			missing = 1'b0;
			n = (chan_count > NUM_CH_DEF) ? NUM_CH_DEF : chan_count;
			if (n > 0) begin
				min_dur = duration[0];
				for (int i = 1; i < n; i++)
					if (duration[i] < min_dur) min_dur = duration[i];
				since_last = t - last_tick;
				o.overrun = (since_last > min_dur);
				for (int i = 0; i < n; i++) begin
					// start idle or expired channels at this tick
					if (chan_phase[i] != PH_RUNNING) begin
						chan_phase[i] = PH_RUNNING;
						start_time[i] = t;
					end
					due = start_time[i] + duration[i];
					if (t >= due) begin
						o.fired[i] = 1'b1;
						if (repeating[i]) begin
							late_at = start_time[i] + (duration[i] << 1);
							if (t > late_at) o.late[i] = 1'b1;
							start_time[i] = t;
						end else begin
							chan_phase[i] = PH_EXPIRED;
						end
						if (!tasks[i]) missing = 1'b1;
					end
				end
			end
			last_tick = t;
			o.all_ok = !o.overrun && (o.late == '0) && !missing;
			outcomes_due = {outcomes_due, o};
		endfunction

		// Compare one result beat with the oldest expected outcome
		function void check_beat(logic [MASK_W-1:0] fired, logic [MASK_W-1:0] late,
				logic overrun, logic all_ok);
			tick_outcome_t e;
			if (outcomes_due.size() == 0) begin
				$display("%0t: result beat with nothing expected (fired %h late %h)",
					$time, fired, late);
				errors++;
				return;
			end
			e = outcomes_due.pop_front();
			if (fired !== e.fired) begin
				$display("%0t: fired_mask expected %h actual %h", $time, e.fired, fired);
				errors++;
			end
			if (late !== e.late) begin
				$display("%0t: late_mask expected %h actual %h", $time, e.late, late);
				errors++;
			end
			if (overrun !== e.overrun) begin
				$display("%0t: overrun expected %b actual %b", $time, e.overrun, overrun);
				errors++;
			end
			if (all_ok !== e.all_ok) begin
				$display("%0t: all_ok expected %b actual %b", $time, e.all_ok, all_ok);
				errors++;
			end
		endfunction

		function int waiting();
			return outcomes_due.size();
		endfunction
	endclass

endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import mcstg_pkg::*;
	import tick_check_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASES = 12;
	localparam int PHASE_TICKS = 108;
	// index past the last register, must be ignored
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [TIME_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [TIME_W-1:0] tick_ms = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [MASK_W-1:0] fired_mask;
	logic [MASK_W-1:0] late_mask;
	logic              overrun;
	logic              all_ok;

	timer_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_request = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;

	multi_channel_soft_timer_group dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.tick_ms(tick_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fired_mask(fired_mask),
		.late_mask(late_mask),
		.overrun(overrun),
		.all_ok(all_ok)
	);

	always #10 clk = ~clk;

	// Receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seen != hold_request) begin
			hold_seen <= hold_request;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Note accepted ticks, check accepted result beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_tick(tick_ms);
			if (out_valid && !out_stall) sb.check_beat(fired_mask, late_mask, overrun, all_ok);
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one tick beat, idling first at random, and hold it until taken
	task automatic send_tick(input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		tick_ms <= t;
		do @(posedge clk); while (in_stall);
	endtask

	// Drive one register write; the caller lowers the enable
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_setting(input logic [TIME_W-1:0] cnt, input logic [TIME_W-1:0] d0,
			input logic [TIME_W-1:0] d1, input logic [TIME_W-1:0] d2,
			input logic [TIME_W-1:0] d3, input logic [TIME_W-1:0] rep,
			input logic [TIME_W-1:0] tsk);
		write_reg(REG_COUNT, cnt);
		write_reg(REG_DUR0, d0);
		write_reg(REG_DUR1, d1);
		write_reg(REG_DUR2, d2);
		write_reg(REG_DUR3, d3);
		write_reg(REG_REPEAT, rep);
		write_reg(REG_TASKS, tsk);
		cfg_we <= 1'b0;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [TIME_W-1:0] edge_ticks [12];
		logic [TIME_W-1:0] durs [DUR_CFG];
		logic [TIME_W-1:0] cur;
		logic [TIME_W-1:0] d;
		logic [TIME_W-1:0] dd;
		logic [TIME_W-1:0] step_ms;
		logic [TIME_W-1:0] cnt;
		logic [TIME_W-1:0] rep;
		logic [TIME_W-1:0] tsk;
		int r;
		int kind;
		sb = new();
		edge_ticks = '{32'd10, 32'd11, 32'd12, 32'd13, 32'd14, 32'd20, 32'h7FFF_FFF0,
			32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 32'd5, 32'd5};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first tick is measured against a zero previous time
		apply_setting(32'd2, DUR_RESET, DUR_RESET, DUR_RESET, DUR_RESET,
			REPEAT_RESET, TASKS_RESET);
		send_tick(32'd1500);
		send_tick(32'd2500);
		send_tick(32'd5000);
		drain_results();

		// oversized count, zero and extreme durations, mixed modes, missing tasks
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		apply_setting(32'd7, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000, 32'h6, 32'hD);
		foreach (edge_ticks[i]) send_tick(edge_ticks[i]);
		drain_results();

		// no channel in use
		apply_setting(32'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'h0, 32'h0);
		send_tick(32'd0);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'd12345);
		drain_results();

		// random phases over settings and idling modes
		for (int p = 0; p < PHASES; p++) begin
			cnt = (p == 3 || p == 9) ? 0 : (p % 3 == 0) ? 4 : $urandom_range(1, 4);
			kind = (p + p / 4) % 4;
			for (int c = 0; c < DUR_CFG; c++) begin
				case (kind)
					0, 1: durs[c] = $urandom_range(1, 64);
					2: begin
						r = $urandom_range(0, 2);
						durs[c] = (r == 0) ? 32'd1 : (r == 1) ? 32'hFFFF_FFFF
							: $urandom_range(1, 500);
					end
					default: begin
						durs[c] = $urandom;
						if (durs[c] == 0) durs[c] = 32'd1;
					end
				endcase
			end
			if (p == 1) begin
				rep = 0;
				tsk = 0;
			end else if (p == 2) begin
				rep = 15;
				tsk = 15;
			end else begin
				rep = $urandom_range(0, 15);
				tsk = $urandom_range(0, 15);
			end
			apply_setting(cnt, durs[0], durs[1], durs[2], durs[3], rep, tsk);

			case (p % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 78;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 78;
				end
				default: begin
					tx_idle_pct = 8;
					rx_stall_pct = 8;
				end
			endcase
			// long receiver hold-off while ticks keep coming
			if (p == 4) hold_request = hold_request + 1;

			cur = (p % 2) ? 32'hFFFF_FF00 + $urandom_range(0, 200) : $urandom;
			for (int k = 0; k < PHASE_TICKS; k++) begin
				d = durs[$urandom_range(0, DUR_CFG - 1)];
				dd = (d > 1000) ? 32'd1000 : d;
				r = $urandom_range(99);
				if (r < 30) step_ms = $urandom_range(0, dd);
				else if (r < 50) step_ms = d + $urandom_range(0, 2) - 1;
				else if (r < 60) step_ms = (d << 1) + $urandom_range(0, 2);
				else if (r < 70) step_ms = d * 3 + $urandom_range(0, dd);
				else if (r < 80) step_ms = 0;
				else if (r < 90) step_ms = $urandom;
				else step_ms = 32'd0 - $urandom_range(1, dd);
				cur = cur + step_ms;
				send_tick(cur);
			end
			drain_results();
		end

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
